>>> rtl/i4dp_pkg.sv
// i4dp_pkg: words, queue element and fixed-point constants of the int4 weight dot product
// depends on nothing; used by every module of the block

package i4dp_pkg;

  // fraction bits of the Q8.8 formats
  localparam int unsigned FRAC_BITS = 8;

  // widths of the datapath
  localparam int unsigned ACT_W = 16;
  localparam int unsigned WEIGHT_W = 4;
  localparam int unsigned PROD_W = 20;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned SCALED_W = 48;

  // scale after reset, 1.0 in Q8.8
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // clip bounds of the 32-bit result
  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

  // one input word
  typedef struct packed {
    logic signed [ACT_W-1:0] activation;
    logic [7:0]              packed_weights;
    logic                    high_half;
    logic                    last_element;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic signed [SUM_W-1:0] dot_result;
    logic                    saturated;
  } out_word_t;

  // queue element: decoded product and end-of-row mark
  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic                     last;
  } elem_t;

endpackage

>>> rtl/int4_weight_dot_product.sv
// int4_weight_dot_product: top level of the int4 weight dot product
// depends on i4dp_pkg, i4dp_front, i4dp_queue, i4dp_back
//
//  channel  handshake               word
//  item     item_valid/item_stall   activation, packed_weights, high_half, last_element
//  result   result_valid/result_stall  dot_result, saturated
//  cfg      cfg_valid/cfg_ready     weight_scale (always ready)
//
// one input word per cycle while the queue has room; the front decodes and multiplies in the accept cycle
// a result is shown after its row's last word is taken and has gone through, in order,
// (queue pop with accumulate, scale multiply, round and clip into the output register)
// reset clears the accumulator, the queue and the stages, and sets weight_scale to 1.0
// item_stall rises when the QUEUE_DEPTH-word queue is full; result_stall backs up the stages

module int4_weight_dot_product #(
  parameter int QUEUE_DEPTH = 4  // 2 to 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  i4dp_pkg::in_word_t             item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output i4dp_pkg::out_word_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [i4dp_pkg::SCALE_W-1:0]   cfg_data
);

  logic [i4dp_pkg::SCALE_W-1:0] weight_scale;
  logic                         queue_full;
  logic                         push;
  i4dp_pkg::elem_t              push_elem;
  logic                         pop;
  logic                         head_valid;
  i4dp_pkg::elem_t              head_elem;

  // scale register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_scale <= i4dp_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weight_scale <= cfg_data;
    end
  end

  i4dp_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .queue_full (queue_full),
    .item_stall (item_stall),
    .push       (push),
    .push_elem  (push_elem)
  );

  i4dp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_elem  (push_elem),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_elem  (head_elem)
  );

  i4dp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .weight_scale (weight_scale),
    .head_valid   (head_valid),
    .head_elem    (head_elem),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/i4dp_front.sv
// i4dp_front: takes input words, picks and decodes the weight nibble, forms the product
// depends on i4dp_pkg; feeds i4dp_queue

module i4dp_front (
  input  logic             item_valid,
  input  i4dp_pkg::in_word_t item,
  input  logic             queue_full,
  output logic             item_stall,
  output logic             push,
  output i4dp_pkg::elem_t  push_elem
);

  logic [i4dp_pkg::WEIGHT_W-1:0]      nibble;
  logic signed [i4dp_pkg::PROD_W-1:0] act_ext;
  logic signed [i4dp_pkg::PROD_W-1:0] weight_ext;

  // accept whenever the queue has room
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  // nibble select and two's complement decode
  assign nibble     = item.high_half ? item.packed_weights[7:4] : item.packed_weights[3:0];
  assign act_ext    = i4dp_pkg::PROD_W'(item.activation);
  assign weight_ext = i4dp_pkg::PROD_W'($signed(nibble));

  // product is exact in 20 bits
  assign push_elem.product = act_ext * weight_ext;
  assign push_elem.last    = item.last_element;

endmodule

>>> rtl/i4dp_queue.sv
// i4dp_queue: short queue of decoded products between front and back
// depends on i4dp_pkg

module i4dp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i4dp_pkg::elem_t push_elem,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output i4dp_pkg::elem_t head_elem
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  i4dp_pkg::elem_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_elem  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_elem;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("fill count lost a write");

endmodule

>>> rtl/i4dp_back.sv
// i4dp_back: accumulates products, scales the row sum, rounds and clips the result
// depends on i4dp_pkg; reads from i4dp_queue

module i4dp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [i4dp_pkg::SCALE_W-1:0]   weight_scale,
  input  logic                           head_valid,
  input  i4dp_pkg::elem_t                head_elem,
  output logic                           pop,
  output logic                           result_valid,
  input  logic                           result_stall,
  output i4dp_pkg::out_word_t            result
);

  localparam int SHIFT_W = i4dp_pkg::SCALED_W - i4dp_pkg::FRAC_BITS;
  localparam logic signed [i4dp_pkg::SCALED_W-1:0] ROUND_BIAS =
    i4dp_pkg::SCALED_W'(1) << (i4dp_pkg::FRAC_BITS - 1);

  logic signed [i4dp_pkg::SUM_W-1:0]    acc;
  logic signed [i4dp_pkg::SUM_W:0]      acc_wide;
  logic signed [i4dp_pkg::SUM_W-1:0]    acc_clip;

  logic                                 m_valid;
  logic signed [i4dp_pkg::SUM_W-1:0]    m_sum;
  logic signed [i4dp_pkg::SCALED_W:0]   mult_full;

  logic                                 p_valid;
  logic signed [i4dp_pkg::SCALED_W-1:0] p_prod;
  logic signed [i4dp_pkg::SCALED_W-1:0] rounded;
  logic signed [SHIFT_W-1:0]            shifted;
  logic                                 out_over;

  logic                                 out_load;
  logic                                 p_load;
  logic                                 pop_last;

  // stage handshakes, output side first
  assign out_load = p_valid && (!result_valid || !result_stall);
  assign p_load   = m_valid && (!p_valid || out_load);
  assign pop      = head_valid && (!head_elem.last || !m_valid || p_load);
  assign pop_last = pop && head_elem.last;

  // saturating accumulate
  assign acc_wide = (i4dp_pkg::SUM_W + 1)'(acc) + (i4dp_pkg::SUM_W + 1)'(head_elem.product);
  always_comb begin
    if (acc_wide[i4dp_pkg::SUM_W] != acc_wide[i4dp_pkg::SUM_W-1]) begin
      acc_clip = acc_wide[i4dp_pkg::SUM_W] ? i4dp_pkg::SUM_MIN : i4dp_pkg::SUM_MAX;
    end else begin
      acc_clip = acc_wide[i4dp_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (pop) begin
      acc <= head_elem.last ? '0 : acc_clip;
    end
  end

  // row sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (pop_last) begin
      m_valid <= 1'b1;
    end else if (p_load) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      m_sum <= acc_clip;
    end
  end

  // scale multiply stage
  assign mult_full = m_sum * $signed({1'b0, weight_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_load) begin
      p_valid <= 1'b1;
    end else if (out_load) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_prod <= mult_full[i4dp_pkg::SCALED_W-1:0];
    end
  end

  // round half up, drop fraction, clip to 32 bits
  assign rounded  = p_prod + ROUND_BIAS;
  assign shifted  = rounded[i4dp_pkg::SCALED_W-1:i4dp_pkg::FRAC_BITS];
  assign out_over = (shifted[SHIFT_W-1:i4dp_pkg::SUM_W-1] != '0) &&
                    (shifted[SHIFT_W-1:i4dp_pkg::SUM_W-1] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.saturated <= out_over;
      if (out_over) begin
        result.dot_result <= shifted[SHIFT_W-1] ? i4dp_pkg::SUM_MIN : i4dp_pkg::SUM_MAX;
      end else begin
        result.dot_result <= shifted[i4dp_pkg::SUM_W-1:0];
      end
    end
  end

  // a flagged result sits on a clip bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.dot_result == i4dp_pkg::SUM_MAX || result.dot_result == i4dp_pkg::SUM_MIN))
    else $error("saturated flag without clipped value");
  // the end of a row clears the accumulator
  a_row_clear: assert property (@(posedge clk) disable iff (rst) pop_last |=> acc == '0)
    else $error("accumulator not cleared after row end");
  // a held product is not lost while the output waits
  a_p_hold: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !out_load) |=> (p_valid && $stable(p_prod)))
    else $error("scaled product dropped while output stalled");

endmodule
